// ----- hw/rtl/hmbs_pkg.sv -----
// Shared constants, codes and helper functions for the height map sampler.
package hmbs_pkg;

    // Map geometry
    localparam int MAX_SIDE    = 256;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
    // signed grid coordinate: integer part of Q8.8 plus centring offset
    localparam int CRD_W       = ((SIDE_W > 8) ? SIDE_W : 8) + 2;

    // Field widths
    localparam int CFG_W    = 9;
    localparam int IDX_W    = 16;
    localparam int TEX_W    = 8;
    localparam int POS_W    = 16;
    localparam int FRAC_W   = 8;
    localparam int HEIGHT_W = 15;

    // APB
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Arithmetic constants: height = floor(floor(S * 100 / 256) / 255)
    localparam int                HEIGHT_MAX = 25600;
    localparam logic [6:0]        SCALE_NUM  = 7'd100;
    // ceil(2^32 / 255), exact for dividends below 2^32 / 254
    localparam logic [24:0]       RECIP_255  = 25'd16843010;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register indexes
    localparam logic REG_MAP_WIDTH = 1'b0;
    localparam logic REG_MAP_DEPTH = 1'b1;

    // Reset value of both side registers
    localparam logic [CFG_W-1:0] SIDE_RESET = CFG_W'(MAX_SIDE);

    // Clamp a side register to [1, MAX_SIDE]
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (32'(v) > MAX_SIDE) begin
            r = SIDE_W'(MAX_SIDE);
        end else begin
            r = SIDE_W'(v);
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/heightmap_bilinear_sampler.sv -----
// Height map store with a pipelined bilinear query path and APB registers.
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ------------------------------------------------
//  input    in         i_valid / o_ready    i_cmd, i_write_index, i_write_value, i_query_x/z
//  output   out        o_valid / i_ready    o_height_out, o_out_of_range
//  config   in         psel/penable/pready  paddr, pwrite, pwdata, prdata
//
//  One transaction is taken per cycle unless the output is held. A query passes through seven
//  register stages: address prep, address multiply, store read, two weighting multiplies,
//  scaling by 100/256 and the reciprocal multiply for /255.
//  The store is two identical copies, each with one write and two read ports, so the four
//  neighbour texels are fetched in the same cycle. A write reaches the store at the same stage at
//  which queries read it, so later queries see it. Reset clears control state only; the store
//  has no clearing pass. A stall at the output freezes every stage; nothing is lost or repeated.
module heightmap_bilinear_sampler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_cmd,
    input  logic [hmbs_pkg::IDX_W-1:0]        i_write_index,
    input  logic [hmbs_pkg::TEX_W-1:0]        i_write_value,
    input  logic signed [hmbs_pkg::POS_W-1:0] i_query_x,
    input  logic signed [hmbs_pkg::POS_W-1:0] i_query_z,
    // output channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [hmbs_pkg::HEIGHT_W-1:0]     o_height_out,
    output logic                              o_out_of_range,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hmbs_pkg::PADDR_W-1:0]      paddr,
    input  logic [hmbs_pkg::PDATA_W-1:0]      pwdata,
    output logic [hmbs_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import hmbs_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_map_width;
    logic [CFG_W-1:0] r_map_depth;
    logic             s_cfg_wr;
    logic             s_cfg_idx;

    assign pready    = 1'b1;
    assign s_cfg_idx = paddr[2];
    assign s_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width <= SIDE_RESET;
            r_map_depth <= SIDE_RESET;
        end else if (s_cfg_wr) begin
            if (s_cfg_idx == REG_MAP_WIDTH) begin
                r_map_width <= pwdata[CFG_W-1:0];
            end else begin
                r_map_depth <= pwdata[CFG_W-1:0];
            end
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (s_cfg_idx == REG_MAP_WIDTH) begin
            prdata = PDATA_W'(r_map_width);
        end else begin
            prdata = PDATA_W'(r_map_depth);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves unless the result is held
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic s_en;

    assign s_en    = !r_v7 || i_ready;
    assign o_ready = s_en;

    // ------------------------------------------------------------------
    // Stage 1: grid coordinates and bounds
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0]       s_w, s_d;
    logic signed [CRD_W-1:0] s_x0, s_z0, s_hw, s_hd, s_w_ext, s_d_ext;
    logic signed [CRD_W-1:0] s_row0, s_row1, s_col0, s_col1;

    assign s_w     = clamp_side(r_map_width);
    assign s_d     = clamp_side(r_map_depth);
    assign s_x0    = {{(CRD_W-8){i_query_x[POS_W-1]}}, i_query_x[POS_W-1:FRAC_W]};
    assign s_z0    = {{(CRD_W-8){i_query_z[POS_W-1]}}, i_query_z[POS_W-1:FRAC_W]};
    assign s_hw    = {{(CRD_W-SIDE_W+1){1'b0}}, s_w[SIDE_W-1:1]};
    assign s_hd    = {{(CRD_W-SIDE_W+1){1'b0}}, s_d[SIDE_W-1:1]};
    assign s_w_ext = {{(CRD_W-SIDE_W){1'b0}}, s_w};
    assign s_d_ext = {{(CRD_W-SIDE_W){1'b0}}, s_d};
    assign s_row0  = s_x0 + s_hw;
    assign s_row1  = s_row0 + CRD_W'(1);
    assign s_col0  = s_z0 + s_hd;
    assign s_col1  = s_col0 + CRD_W'(1);

    logic                r_cmd1;
    logic [IDX_W-1:0]    r_widx1;
    logic [TEX_W-1:0]    r_wval1;
    logic [FRAC_W-1:0]   r_fx1, r_fz1;
    logic [SIDE_W-1:0]   r_w1, r_row0_1, r_row1_1, r_col0_1, r_col1_1;
    logic                r_rin0_1, r_rin1_1, r_cin0_1, r_cin1_1;

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_cmd1   <= i_cmd;
            r_widx1  <= i_write_index;
            r_wval1  <= i_write_value;
            r_fx1    <= i_query_x[FRAC_W-1:0];
            r_fz1    <= i_query_z[FRAC_W-1:0];
            r_w1     <= s_w;
            r_row0_1 <= s_row0[SIDE_W-1:0];
            r_row1_1 <= s_row1[SIDE_W-1:0];
            r_col0_1 <= s_col0[SIDE_W-1:0];
            r_col1_1 <= s_col1[SIDE_W-1:0];
            r_rin0_1 <= (s_row0 >= 0) && (s_row0 < s_d_ext);
            r_rin1_1 <= (s_row1 >= 0) && (s_row1 < s_d_ext);
            r_cin0_1 <= (s_col0 >= 0) && (s_col0 < s_w_ext);
            r_cin1_1 <= (s_col1 >= 0) && (s_col1 < s_w_ext);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: linear texel addresses (row * width + col)
    // ------------------------------------------------------------------
    logic [2*SIDE_W-1:0] s_p0, s_p1, s_a00, s_a01, s_a10, s_a11;

    assign s_p0  = (2*SIDE_W)'(r_row0_1) * (2*SIDE_W)'(r_w1);
    assign s_p1  = (2*SIDE_W)'(r_row1_1) * (2*SIDE_W)'(r_w1);
    assign s_a00 = s_p0 + (2*SIDE_W)'(r_col0_1);
    assign s_a01 = s_p0 + (2*SIDE_W)'(r_col1_1);
    assign s_a10 = s_p1 + (2*SIDE_W)'(r_col0_1);
    assign s_a11 = s_p1 + (2*SIDE_W)'(r_col1_1);

    logic              r_cmd2;
    logic [IDX_W-1:0]  r_widx2;
    logic [TEX_W-1:0]  r_wval2;
    logic [FRAC_W-1:0] r_fx2, r_fz2;
    logic [ADDR_W-1:0] r_a00, r_a01, r_a10, r_a11;
    logic [3:0]        r_in2;   // {in11, in10, in01, in00}

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_cmd2  <= r_cmd1;
            r_widx2 <= r_widx1;
            r_wval2 <= r_wval1;
            r_fx2   <= r_fx1;
            r_fz2   <= r_fz1;
            r_a00   <= s_a00[ADDR_W-1:0];
            r_a01   <= s_a01[ADDR_W-1:0];
            r_a10   <= s_a10[ADDR_W-1:0];
            r_a11   <= s_a11[ADDR_W-1:0];
            r_in2   <= {r_rin1_1 && r_cin1_1, r_rin1_1 && r_cin0_1,
                        r_rin0_1 && r_cin1_1, r_rin0_1 && r_cin0_1};
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: texel store, two copies; writes land here in order
    // ------------------------------------------------------------------
    logic [TEX_W-1:0]  r_mem_a [STORE_DEPTH];
    logic [TEX_W-1:0]  r_mem_b [STORE_DEPTH];
    logic              s_mem_wr;
    logic [ADDR_W-1:0] s_mem_wa;
    logic [TEX_W-1:0]  r_h00, r_h01, r_h10, r_h11;

    assign s_mem_wr = s_en && r_v2 && (r_cmd2 == CMD_WRITE) && (32'(r_widx2) < STORE_DEPTH);
    assign s_mem_wa = ADDR_W'(r_widx2);

    // copy A serves row x0, copy B row x0+1
    always_ff @(posedge i_clk) begin
        if (s_mem_wr) begin
            r_mem_a[s_mem_wa] <= r_wval2;
        end
        if (s_en) begin
            r_h00 <= r_mem_a[r_a00];
            r_h01 <= r_mem_a[r_a01];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_mem_wr) begin
            r_mem_b[s_mem_wa] <= r_wval2;
        end
        if (s_en) begin
            r_h10 <= r_mem_b[r_a10];
            r_h11 <= r_mem_b[r_a11];
        end
    end

    logic [FRAC_W-1:0] r_fx3, r_fz3;
    logic [3:0]        r_in3;

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_fx3 <= r_fx2;
            r_fz3 <= r_fz2;
            r_in3 <= r_in2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: weighting along z, off-map texels count as zero
    // ------------------------------------------------------------------
    logic [TEX_W-1:0]  s_e00, s_e01, s_e10, s_e11;
    logic [FRAC_W:0]   s_wz0;
    logic [16:0]       s_t0, s_t1;

    assign s_e00 = r_in3[0] ? r_h00 : '0;
    assign s_e01 = r_in3[1] ? r_h01 : '0;
    assign s_e10 = r_in3[2] ? r_h10 : '0;
    assign s_e11 = r_in3[3] ? r_h11 : '0;
    assign s_wz0 = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, r_fz3};
    assign s_t0  = 17'(s_e00) * 17'(s_wz0) + 17'(s_e01) * 17'(r_fz3);
    assign s_t1  = 17'(s_e10) * 17'(s_wz0) + 17'(s_e11) * 17'(r_fz3);

    logic [16:0]       r_t0, r_t1;
    logic [FRAC_W-1:0] r_fx4;
    logic              r_oor4;

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_t0   <= s_t0;
            r_t1   <= s_t1;
            r_fx4  <= r_fx3;
            r_oor4 <= !(&r_in3);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: weighting along x
    // ------------------------------------------------------------------
    logic [FRAC_W:0] s_wx0;
    logic [25:0]     s_sum;
    logic [23:0]     r_sum5;
    logic            r_oor5;

    assign s_wx0 = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, r_fx4};
    assign s_sum = 26'(s_wx0) * 26'(r_t0) + 26'(r_fx4) * 26'(r_t1);

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_sum5 <= s_sum[23:0];
            r_oor5 <= r_oor4;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: scale by 100 and drop the 1/256 part of the divisor
    // ------------------------------------------------------------------
    logic [30:0] s_scaled;
    logic [22:0] r_m6;
    logic        r_oor6;

    assign s_scaled = 31'(r_sum5) * 31'(SCALE_NUM);

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_m6   <= s_scaled[30:8];
            r_oor6 <= r_oor5;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: divide by 255 through the reciprocal, output register
    // ------------------------------------------------------------------
    logic [47:0]         s_recip;
    logic [HEIGHT_W-1:0] r_height7;
    logic                r_oor7;

    assign s_recip = 48'(r_m6) * 48'(RECIP_255);

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_height7 <= s_recip[32+HEIGHT_W-1:32];
            r_oor7    <= r_oor6;
        end
    end

    // ------------------------------------------------------------------
    // Valid chain; writes leave the pipeline after the store
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (s_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && (r_cmd2 == CMD_QUERY);
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    assign o_valid        = r_v7;
    assign o_height_out   = r_height7;
    assign o_out_of_range = r_oor7;

`ifndef SYNTH
    // a write transaction never produces a result
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_en && r_v2 && (r_cmd2 == CMD_WRITE)) |=> !r_v3)
        else $error("write transaction entered the result path");

    // result stays within the scaled height range
    a_height_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_height_out) <= HEIGHT_MAX))
        else $error("height result above range");

    // a held output freezes the inner stages
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_en |=> ($stable(r_v3) && $stable(r_v5) && $stable(r_v7)))
        else $error("pipeline moved during a stall");

    // a query in the last inner stage reaches the output when the pipe advances
    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_en && r_v6) |=> o_valid)
        else $error("query lost before output register");
`endif

endmodule
